/* hw/rtl/bip_pkg.sv */
// bip_pkg: shared types and codes for the box index predicate core
// strategy codes and the per-dimension compare flags; no dependencies
package bip_pkg;

   typedef enum logic [3:0] {
      OP_LEFT         = 4'd0,
      OP_OVER_LEFT    = 4'd1,
      OP_OVERLAP      = 4'd2,
      OP_OVER_RIGHT   = 4'd3,
      OP_RIGHT        = 4'd4,
      OP_SAME         = 4'd5,
      OP_CONTAINS     = 4'd6,
      OP_CONTAINED_BY = 4'd7
   } op_type;

   // outcome of one dimension's compares, each flag true when the test passes
   typedef struct packed {
      logic left;         // key high < query low
      logic right;        // key low > query high
      logic hi_le;        // key high <= query high
      logic lo_ge;        // key low >= query low
      logic same;         // both intervals equal
      logic overlap;      // intervals intersect
      logic key_holds;    // key interval covers query interval
      logic query_holds;  // query interval covers key interval
   } dim_flags_type;

endpackage

/* hw/rtl/bip_dim_compare.sv */
// bip_dim_compare: orders the corners of one dimension and compares key
// against query; combinational, uses bip_pkg::dim_flags_type
module bip_dim_compare #(
   parameter int COORD_BITS = 32
) (
   input  logic signed [COORD_BITS-1:0] key_lo,
   input  logic signed [COORD_BITS-1:0] key_hi,
   input  logic                         key_has,
   input  logic signed [COORD_BITS-1:0] query_lo,
   input  logic signed [COORD_BITS-1:0] query_hi,
   input  logic                         query_has,
   output bip_pkg::dim_flags_type       flags
);

   logic signed [COORD_BITS-1:0] ka, kb, qa, qb;
   logic signed [COORD_BITS-1:0] klo, khi, qlo, qhi;

   // a missing dimension reads as the interval [0,0]
   assign ka = key_has   ? key_lo   : '0;
   assign kb = key_has   ? key_hi   : '0;
   assign qa = query_has ? query_lo : '0;
   assign qb = query_has ? query_hi : '0;

   assign klo = (ka < kb) ? ka : kb;
   assign khi = (ka < kb) ? kb : ka;
   assign qlo = (qa < qb) ? qa : qb;
   assign qhi = (qa < qb) ? qb : qa;

   always_comb begin
      flags.left        = khi < qlo;
      flags.right       = klo > qhi;
      flags.hi_le       = khi <= qhi;
      flags.lo_ge       = klo >= qlo;
      flags.same        = (klo == qlo) && (khi == qhi);
      flags.overlap     = !((klo > qhi) || (khi < qlo));
      // containment ignores dimensions the contained box lacks
      flags.key_holds   = !query_has || ((klo <= qlo) && (khi >= qhi));
      flags.query_holds = !key_has || ((qlo <= klo) && (qhi >= khi));
   end

endmodule

/* hw/rtl/bip_fold.sv */
// bip_fold: running flags across the dimensions of one box pair and the
// final strategy decode; uses bip_pkg types and strategy codes
module bip_fold (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   last_dim,
   input  logic [3:0]             operation,
   input  logic                   is_leaf,
   input  bip_pkg::dim_flags_type flags,
   output logic                   match
);

   logic       first_pending_ff, first_pending_in;
   logic [3:0] axis0_ff, axis0_in;
   logic       same_ff, same_in;
   logic       overlap_ff, overlap_in;
   logic       key_holds_ff, key_holds_in;
   logic       query_holds_ff, query_holds_in;

   logic [3:0] axis0_now;
   logic       left, right, oleft, oright;

   // axis 0 flags come from the first dimension of the pair
   assign axis0_now = first_pending_ff ? {flags.lo_ge, flags.hi_le, flags.right, flags.left}
                                       : axis0_ff;

   assign same_in        = same_ff & flags.same;
   assign overlap_in     = overlap_ff & flags.overlap;
   assign key_holds_in   = key_holds_ff & flags.key_holds;
   assign query_holds_in = query_holds_ff & flags.query_holds;
   assign axis0_in       = axis0_now;
   assign first_pending_in = 1'b0;

   assign left   = axis0_now[0];
   assign right  = axis0_now[1];
   assign oleft  = axis0_now[2] && !left && !right;
   assign oright = axis0_now[3] && !left && !right;

   always_comb begin
      match = 1'b0;
      if (is_leaf) begin
         case (operation)
            bip_pkg::OP_LEFT:         match = left;
            bip_pkg::OP_OVER_LEFT:    match = oleft;
            bip_pkg::OP_OVERLAP:      match = overlap_in;
            bip_pkg::OP_OVER_RIGHT:   match = oright;
            bip_pkg::OP_RIGHT:        match = right;
            bip_pkg::OP_SAME:         match = same_in;
            bip_pkg::OP_CONTAINS:     match = key_holds_in;
            bip_pkg::OP_CONTAINED_BY: match = query_holds_in;
            default:                  match = 1'b0;
         endcase
      end else begin
         // internal nodes use the looser test of each strategy
         case (operation)
            bip_pkg::OP_LEFT, bip_pkg::OP_OVER_LEFT:         match = oleft;
            bip_pkg::OP_OVERLAP, bip_pkg::OP_CONTAINED_BY:   match = overlap_in;
            bip_pkg::OP_OVER_RIGHT, bip_pkg::OP_RIGHT:       match = right;
            bip_pkg::OP_SAME, bip_pkg::OP_CONTAINS:          match = key_holds_in;
            default:                                         match = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (advance && last_dim)) begin
         first_pending_ff <= 1'b1;
         axis0_ff         <= '0;
         same_ff          <= 1'b1;
         overlap_ff       <= 1'b1;
         key_holds_ff     <= 1'b1;
         query_holds_ff   <= 1'b1;
      end else if (advance) begin
         first_pending_ff <= first_pending_in;
         axis0_ff         <= axis0_in;
         same_ff          <= same_in;
         overlap_ff       <= overlap_in;
         key_holds_ff     <= key_holds_in;
         query_holds_ff   <= query_holds_in;
      end
   end

endmodule

/* hw/rtl/box_index_predicate_core.sv */
// box_index_predicate_core: top level, input register, per-dimension compare,
// running fold and result register; uses bip_pkg, bip_dim_compare, bip_fold
//
// Tests an r-tree key box against a query box for one strategy. Each req_
// transaction carries one dimension (axis 0 first) with both boxes' corners,
// the presence flags, and on the final dimension (req_last_dim) the strategy
// and leaf flag that apply. Only the final dimension of a pair produces a
// rsp_ transaction carrying rsp_match; earlier dimensions produce nothing.
// A final dimension passes the input register, then the result register,
// before rsp_valid shows its result.
// Throughput: one dimension per cycle while no final dimension stalls, set by
// the single compare stage between the input register and the fold registers.
// When the receiver stalls, the result register holds; the input register
// still drains non-final dimensions, and req_ready drops only when a final
// dimension waits behind an untaken result.
// Reset clears both valid flags and returns the running flags to the start
// of a new box pair, with no clearing pass.
module box_index_predicate_core #(
   parameter int COORD_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [3:0]                   req_operation,
   input  logic                         req_is_leaf,
   input  logic signed [COORD_BITS-1:0] req_key_lo,
   input  logic signed [COORD_BITS-1:0] req_key_hi,
   input  logic                         req_key_has,
   input  logic signed [COORD_BITS-1:0] req_query_lo,
   input  logic signed [COORD_BITS-1:0] req_query_hi,
   input  logic                         req_query_has,
   input  logic                         req_last_dim,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_match
);

   logic                         s1_valid_ff, s1_valid_in;
   logic [3:0]                   s1_operation_ff;
   logic                         s1_is_leaf_ff;
   logic signed [COORD_BITS-1:0] s1_key_lo_ff, s1_key_hi_ff;
   logic                         s1_key_has_ff;
   logic signed [COORD_BITS-1:0] s1_query_lo_ff, s1_query_hi_ff;
   logic                         s1_query_has_ff;
   logic                         s1_last_ff;

   logic                         out_valid_ff, out_valid_in;
   logic                         out_match_ff;

   logic                         s1_advance;
   logic                         req_take;
   logic                         fold_match;
   bip_pkg::dim_flags_type       dim_flags;

   // non-final dimensions never need the result register
   assign s1_advance = s1_valid_ff && (!s1_last_ff || !out_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_take   = req_valid && req_ready;

   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_advance);
   assign out_valid_in = (s1_advance && s1_last_ff) || (out_valid_ff && !rsp_ready);

   bip_dim_compare #(
      .COORD_BITS(COORD_BITS)
   ) u_compare (
      .key_lo    (s1_key_lo_ff),
      .key_hi    (s1_key_hi_ff),
      .key_has   (s1_key_has_ff),
      .query_lo  (s1_query_lo_ff),
      .query_hi  (s1_query_hi_ff),
      .query_has (s1_query_has_ff),
      .flags     (dim_flags)
   );

   bip_fold u_fold (
      .clock     (clock),
      .reset     (reset),
      .advance   (s1_advance),
      .last_dim  (s1_last_ff),
      .operation (s1_operation_ff),
      .is_leaf   (s1_is_leaf_ff),
      .flags     (dim_flags),
      .match     (fold_match)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_operation_ff <= req_operation;
         s1_is_leaf_ff   <= req_is_leaf;
         s1_key_lo_ff    <= req_key_lo;
         s1_key_hi_ff    <= req_key_hi;
         s1_key_has_ff   <= req_key_has;
         s1_query_lo_ff  <= req_query_lo;
         s1_query_hi_ff  <= req_query_hi;
         s1_query_has_ff <= req_query_has;
         s1_last_ff      <= req_last_dim;
      end
      if (s1_advance && s1_last_ff) begin
         out_match_ff <= fold_match;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_match = out_match_ff;

   // an empty input register always takes a transaction
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_ready)
      else $error("req_ready low with empty input register");

   // a non-final dimension never waits in the input register
   a_inner_dim_drains: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_last_ff) |-> s1_advance)
      else $error("non-final dimension stalled");

   // a final dimension that leaves the input register produces a result
   a_final_gives_result: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_last_ff) |=> rsp_valid)
      else $error("final dimension produced no result");

endmodule
